>>> rtl/tafsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Two-level temperature alarm monitor package
// Shared types, register map, event codes and reset values of the monitor.
// ----------------------------------------------------------------------------
package tafsm_pkg;

  // Default width of the dwell counter.
  localparam int CountWidthDefault = 16;

  // Field widths.
  localparam int TempW  = 12;
  localparam int DwellW = 16;
  localparam int CodeW  = 3;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  // Register reset values.
  localparam logic signed [TempW-1:0] PreThrRst   = 12'sd400;
  localparam logic signed [TempW-1:0] AlarmThrRst = 12'sd800;
  localparam logic [DwellW-1:0]       PreDwellRst   = 16'd10;
  localparam logic [DwellW-1:0]       AlarmDwellRst = 16'd10;

  // Register index, taken from the word address.
  typedef enum logic [1:0] {
    REG_PRE_THR     = 2'd0,
    REG_ALARM_THR   = 2'd1,
    REG_PRE_DWELL   = 2'd2,
    REG_ALARM_DWELL = 2'd3
  } reg_idx_e;

  // Event codes reported with each result.
  typedef enum logic [CodeW-1:0] {
    EV_NONE          = 3'd0,
    EV_PRE_ON        = 3'd1,
    EV_PRE_OFF       = 3'd2,
    EV_ALARM         = 3'd3,
    EV_RESET_DONE    = 3'd4,
    EV_RESET_REFUSED = 3'd5
  } event_e;

  // Configuration as seen by the monitor.
  typedef struct packed {
    logic signed [TempW-1:0] pre_thr;
    logic signed [TempW-1:0] alarm_thr;
    logic [DwellW-1:0]       pre_dwell;
    logic [DwellW-1:0]       alarm_dwell;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/tafsm_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Two-level temperature alarm configuration registers
// APB-style register file holding the thresholds and dwell counts.
// ----------------------------------------------------------------------------
module tafsm_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tafsm_pkg::AddrW-1:0]  paddr,
  input  wire logic [tafsm_pkg::DataW-1:0]  pwdata,
  output logic      [tafsm_pkg::DataW-1:0]  prdata,
  output logic                              pready,
  output tafsm_pkg::cfg_t                   cfg_o
);

  tafsm_pkg::cfg_t   cfg_q;
  tafsm_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = tafsm_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write on the access phase of a write transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre_thr     <= tafsm_pkg::PreThrRst;
      cfg_q.alarm_thr   <= tafsm_pkg::AlarmThrRst;
      cfg_q.pre_dwell   <= tafsm_pkg::PreDwellRst;
      cfg_q.alarm_dwell <= tafsm_pkg::AlarmDwellRst;
    end else if (wr_en) begin
      unique case (idx)
        tafsm_pkg::REG_PRE_THR:     cfg_q.pre_thr     <= pwdata[11:0];
        tafsm_pkg::REG_ALARM_THR:   cfg_q.alarm_thr   <= pwdata[11:0];
        tafsm_pkg::REG_PRE_DWELL:   cfg_q.pre_dwell   <= pwdata[15:0];
        tafsm_pkg::REG_ALARM_DWELL: cfg_q.alarm_dwell <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read data; thresholds read back sign extended.
  always_comb begin
    unique case (idx)
      tafsm_pkg::REG_PRE_THR:     prdata = {{20{cfg_q.pre_thr[11]}}, cfg_q.pre_thr};
      tafsm_pkg::REG_ALARM_THR:   prdata = {{20{cfg_q.alarm_thr[11]}}, cfg_q.alarm_thr};
      tafsm_pkg::REG_PRE_DWELL:   prdata = {16'd0, cfg_q.pre_dwell};
      tafsm_pkg::REG_ALARM_DWELL: prdata = {16'd0, cfg_q.alarm_dwell};
      default:                    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/two_level_temp_alarm_fsm_unit.sv
`default_nettype none
// Results: an accepted sample waits in the input register and moves into the result register once that is free.
// Throughput: one sample per cycle while the result channel does not stall; the monitor state is updated
// as the sample moves from the input register into the result register.
// Reset: the monitor returns to normal with the dwell counter and pre-alarm flag
// cleared, both pipeline stages empty, and the registers at their defaults.
// ----------------------------------------------------------------------------
// Two-level temperature alarm monitor
// Five-state monitor with dwell counting between a sample register and a
// result register, plus the APB-style configuration registers.
// ----------------------------------------------------------------------------
module two_level_temp_alarm_fsm_unit #(
  parameter int COUNT_WIDTH = tafsm_pkg::CountWidthDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Sample channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [tafsm_pkg::TempW-1:0]  temperature_i,
  input  wire logic                                reset_pressed_i,
  // Result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     warning_o,
  output logic                                     alarm_o,
  output logic [tafsm_pkg::CodeW-1:0]              event_code_o,
  output logic [2:0]                               monitor_state_o,
  // Configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tafsm_pkg::AddrW-1:0]         paddr,
  input  wire logic [tafsm_pkg::DataW-1:0]         pwdata,
  output logic      [tafsm_pkg::DataW-1:0]         prdata,
  output logic                                     pready
);

  localparam int CmpW = (COUNT_WIDTH > tafsm_pkg::DwellW) ? COUNT_WIDTH : tafsm_pkg::DwellW;

  typedef enum logic [2:0] {
    ST_NORMAL      = 3'd0,
    ST_CHECK_PRE   = 3'd1,
    ST_PRE_ALARM   = 3'd2,
    ST_CHECK_ALARM = 3'd3,
    ST_ALARM       = 3'd4
  } state_e;

  tafsm_pkg::cfg_t cfg;

  // Configuration registers.
  tafsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sample register, monitor state and result register.
  logic                              in_valid_q;
  logic signed [tafsm_pkg::TempW-1:0] temp_q;
  logic                              pressed_q;
  state_e                            state_q, state_d;
  logic [COUNT_WIDTH-1:0]            count_q, count_d;
  logic                              flag_q, flag_d;
  tafsm_pkg::event_e                 event_d;
  logic                              out_valid_q;
  logic                              warning_q;
  logic                              alarm_q;
  tafsm_pkg::event_e                 event_q;
  state_e                            mon_state_q;

  logic                   advance;
  logic                   ge_pre, ge_alarm;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   pre_done, alarm_done;

  // A sample moves on when the result register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Threshold compares and the saturating dwell counter.
  assign ge_pre     = temp_q >= cfg.pre_thr;
  assign ge_alarm   = temp_q >= cfg.alarm_thr;
  assign count_inc  = (count_q == '1) ? count_q : count_q + COUNT_WIDTH'(1);
  assign pre_done   = CmpW'(count_inc) >= CmpW'(cfg.pre_dwell);
  assign alarm_done = CmpW'(count_inc) >= CmpW'(cfg.alarm_dwell);

  // Next-state logic of the monitor.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    flag_d  = flag_q;
    event_d = tafsm_pkg::EV_NONE;
    unique case (state_q)
      ST_CHECK_PRE: begin
        if (!ge_pre) begin
          state_d = ST_NORMAL;
        end else if (ge_alarm) begin
          state_d = ST_CHECK_ALARM;
          count_d = '0;
        end else begin
          count_d = count_inc;
          if (pre_done) begin
            state_d = ST_PRE_ALARM;
            flag_d  = 1'b1;
            event_d = tafsm_pkg::EV_PRE_ON;
          end
        end
      end
      ST_PRE_ALARM: begin
        if (ge_alarm) begin
          state_d = ST_CHECK_ALARM;
          count_d = '0;
        end else if (!ge_pre) begin
          state_d = ST_NORMAL;
          flag_d  = 1'b0;
          event_d = tafsm_pkg::EV_PRE_OFF;
        end
      end
      ST_CHECK_ALARM: begin
        if (!ge_alarm) begin
          state_d = ST_NORMAL;
        end else begin
          count_d = count_inc;
          if (alarm_done) begin
            state_d = ST_ALARM;
            event_d = tafsm_pkg::EV_ALARM;
          end
        end
      end
      ST_ALARM: begin
        if (pressed_q) begin
          if (!ge_pre) begin
            state_d = ST_NORMAL;
            event_d = tafsm_pkg::EV_RESET_DONE;
          end else begin
            event_d = tafsm_pkg::EV_RESET_REFUSED;
          end
        end
      end
      default: begin
        state_d = ST_NORMAL;
        if (ge_alarm) begin
          state_d = ST_CHECK_ALARM;
          count_d = '0;
        end else if (ge_pre) begin
          state_d = ST_CHECK_PRE;
          count_d = '0;
        end
      end
    endcase
  end

  // State, sample and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      temp_q      <= '0;
      pressed_q   <= 1'b0;
      state_q     <= ST_NORMAL;
      count_q     <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      warning_q   <= 1'b0;
      alarm_q     <= 1'b0;
      event_q     <= tafsm_pkg::EV_NONE;
      mon_state_q <= ST_NORMAL;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (in_valid_i && in_ready_o) begin
        temp_q    <= temperature_i;
        pressed_q <= reset_pressed_i;
      end
      if (advance) begin
        state_q     <= state_d;
        count_q     <= count_d;
        flag_q      <= flag_d;
        out_valid_q <= 1'b1;
        warning_q   <= flag_d;
        alarm_q     <= (state_d == ST_ALARM);
        event_q     <= event_d;
        mon_state_q <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign warning_o       = warning_q;
  assign alarm_o         = alarm_q;
  assign event_code_o    = event_q;
  assign monitor_state_o = mon_state_q;

`ifndef SYNTH
  // The alarm output follows the reported state.
  a_alarm_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (alarm_q == (mon_state_q == ST_ALARM)))
    else $error("alarm output disagrees with reported state");

  // Pre-alarm declaration lands in pre-alarm with the flag set.
  a_pre_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && event_q == tafsm_pkg::EV_PRE_ON) |->
      (mon_state_q == ST_PRE_ALARM && warning_q))
    else $error("pre-alarm event without pre-alarm state and flag");

  // A completed alarm reset always returns to normal.
  a_reset_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && event_q == tafsm_pkg::EV_RESET_DONE) |-> (mon_state_q == ST_NORMAL))
    else $error("reset-done event outside normal state");

  // The monitor never sits in pre-alarm without the flag.
  a_flag_in_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRE_ALARM) |-> flag_q)
    else $error("pre-alarm state with flag cleared");

  // The monitor state only moves when a sample advances.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("monitor state changed without a sample");
`endif

endmodule
`default_nettype wire
